>>> hw/rtl/pfb_pkg.sv
// shared types and constants for the ping flood blocker
`default_nettype none

package pfb_pkg;

  localparam int LIMIT_W    = 8;
  localparam int WINDOW_W   = 16;
  localparam int SPAN_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PING_LIMIT     = 3'd0,
    REG_WINDOW_TICKS   = 3'd1,
    REG_BLOCK_TICKS    = 3'd2,
    REG_HOLD_TICKS     = 3'd3,
    REG_CLEAR_TICKS    = 3'd4,
    REG_BLOCKED_PRESET = 3'd5
  } reg_idx_t;

  localparam logic [LIMIT_W-1:0]  PING_LIMIT_RST   = 8'd15;
  localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RST = 16'd150;
  localparam logic [SPAN_W-1:0]   BLOCK_TICKS_RST  = 24'd600;
  localparam logic [SPAN_W-1:0]   HOLD_TICKS_RST   = 24'd600;
  localparam logic [SPAN_W-1:0]   CLEAR_TICKS_RST  = 24'd3000;
  localparam logic                BLOCKED_RST      = 1'b0;

  typedef struct packed {
    logic [LIMIT_W-1:0]  ping_limit;
    logic [WINDOW_W-1:0] window_ticks;
    logic [SPAN_W-1:0]   block_ticks;
    logic [SPAN_W-1:0]   hold_ticks;
    logic [SPAN_W-1:0]   clear_ticks;
    logic                preset_load;
    logic                preset_val;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/pfb_ifs.sv
// valid/ready channel interfaces for pings, results and register writes
`default_nettype none

interface pfb_in_if #(
  parameter int TIME_BITS = 32
) ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now;
  logic                 pre_accept;
  logic                 privileged;

  modport source (output valid, now, pre_accept, privileged, input ready);
  modport sink (input valid, now, pre_accept, privileged, output ready);
endinterface

interface pfb_out_if #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic                  drop;
  logic                  attack_seen;
  logic                  listed_hit;
  logic [COUNT_BITS-1:0] count_now;
  logic [TIME_BITS-1:0]  decay_at;

  modport source (output valid, drop, attack_seen, listed_hit, count_now, decay_at,
                  input ready);
  modport sink (input valid, drop, attack_seen, listed_hit, count_now, decay_at,
                output ready);
endinterface

interface pfb_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [pfb_pkg::CFG_IDX_W-1:0]     index;
  logic [pfb_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pfb_cfg_regs.sv
// configuration register bank
`default_nettype none

module pfb_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [pfb_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  wire logic [pfb_pkg::CFG_DATA_W-1:0] wr_data,
  output pfb_pkg::cfg_t                       cfg
);
  import pfb_pkg::*;

  logic [LIMIT_W-1:0]  ping_limit_r;
  logic [WINDOW_W-1:0] window_ticks_r;
  logic [SPAN_W-1:0]   block_ticks_r;
  logic [SPAN_W-1:0]   hold_ticks_r;
  logic [SPAN_W-1:0]   clear_ticks_r;
  logic                preset_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_limit_r   <= PING_LIMIT_RST;
      window_ticks_r <= WINDOW_TICKS_RST;
      block_ticks_r  <= BLOCK_TICKS_RST;
      hold_ticks_r   <= HOLD_TICKS_RST;
      clear_ticks_r  <= CLEAR_TICKS_RST;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_idx))
        REG_PING_LIMIT:   ping_limit_r   <= wr_data[LIMIT_W-1:0];
        REG_WINDOW_TICKS: window_ticks_r <= wr_data[WINDOW_W-1:0];
        REG_BLOCK_TICKS:  block_ticks_r  <= wr_data[SPAN_W-1:0];
        REG_HOLD_TICKS:   hold_ticks_r   <= wr_data[SPAN_W-1:0];
        REG_CLEAR_TICKS:  clear_ticks_r  <= wr_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign preset_load = wr_en && (wr_idx == REG_BLOCKED_PRESET);

  assign cfg.ping_limit   = ping_limit_r;
  assign cfg.window_ticks = window_ticks_r;
  assign cfg.block_ticks  = block_ticks_r;
  assign cfg.hold_ticks   = hold_ticks_r;
  assign cfg.clear_ticks  = clear_ticks_r;
  assign cfg.preset_load  = preset_load;
  assign cfg.preset_val   = wr_data[0];

endmodule

`default_nettype wire

>>> hw/rtl/pfb_step.sv
// per-ping window, count, block and deadline update
`default_nettype none

module pfb_step #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire pfb_pkg::cfg_t           cfg,
  input  wire logic [TIME_BITS-1:0]    now,
  input  wire logic                    pre_accept,
  input  wire logic                    privileged,
  input  wire logic [TIME_BITS-1:0]    first_seen,
  input  wire logic [COUNT_BITS-1:0]   ping_total,
  input  wire logic                    blocked,
  output logic [TIME_BITS-1:0]         first_seen_nxt,
  output logic [COUNT_BITS-1:0]        ping_total_nxt,
  output logic                         blocked_nxt,
  output logic                         drop,
  output logic                         attack_seen,
  output logic                         listed_hit,
  output logic [TIME_BITS-1:0]         decay_at
);
  import pfb_pkg::*;

  localparam int SUM_W = (TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W;
  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [TIME_BITS-1:0]  age;
  logic                  restart;
  logic [COUNT_BITS-1:0] cnt_base;
  logic [CMP_W-1:0]      cnt_c;
  logic [CMP_W-1:0]      limit_c;
  logic [SUM_W-1:0]      hold_sum;
  logic [SUM_W-1:0]      block_sum;
  logic [SUM_W-1:0]      clear_sum;

  assign age      = now - first_seen;
  assign restart  = (ping_total != '0) && (age > TIME_BITS'(cfg.window_ticks)) &&
                    (CMP_W'(ping_total) < CMP_W'(cfg.ping_limit));
  assign cnt_base = restart ? '0 : ping_total;
  assign ping_total_nxt = (cnt_base != CNT_MAX) ? cnt_base + COUNT_BITS'(1) : cnt_base;
  assign first_seen_nxt = ((ping_total == '0) || restart) ? now : first_seen;

  assign cnt_c     = CMP_W'(ping_total_nxt);
  assign limit_c   = CMP_W'(cfg.ping_limit);
  assign hold_sum  = SUM_W'(now) + SUM_W'(cfg.hold_ticks);
  assign block_sum = SUM_W'(now) + SUM_W'(cfg.block_ticks);
  assign clear_sum = SUM_W'(now) + SUM_W'(cfg.clear_ticks);

  always_comb begin
    drop        = 1'b0;
    attack_seen = 1'b0;
    listed_hit  = 1'b0;
    blocked_nxt = blocked;
    decay_at    = hold_sum[TIME_BITS-1:0];
    priority if (pre_accept && (cnt_c <= CMP_W'(1))) begin
      drop = 1'b0;
    end else if (cnt_c > limit_c) begin
      drop = 1'b1;
      if ((cnt_c == limit_c + CMP_W'(1)) && !blocked) begin
        attack_seen = 1'b1;
        if (!privileged) begin
          blocked_nxt = 1'b1;
          decay_at    = block_sum[TIME_BITS-1:0];
        end
      end
    end else if (blocked) begin
      drop       = 1'b1;
      listed_hit = (cnt_c <= CMP_W'(1));
    end else begin
      decay_at = clear_sum[TIME_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ping_flood_blocker.sv
// top level of the ping flood blocker
// Each accepted ping gives exactly one result. A ping is held in an input register,
// judged by one pass of compare and add logic against the stored window start,
// count and blocked flag, and written with its verdict into the result register,
// where the state is updated at the same edge. The rate is one ping per clock while
// the result side is not stalled; an accepted ping passes the input register and
// then the result register before its result is valid. Register writes are always
// ready; a write to the blocked preset also loads the blocked flag.
`default_nettype none

module ping_flood_blocker #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pfb_in_if.sink     in_if,
  pfb_out_if.source  out_if,
  pfb_cfg_if.sink    cfg_if
);
  import pfb_pkg::*;

  cfg_t cfg;

  logic                  in_vld_r, in_vld_nxt;
  logic [TIME_BITS-1:0]  now_r;
  logic                  pre_r;
  logic                  priv_r;
  logic                  out_vld_r, out_vld_nxt;
  logic                  drop_r, attack_r, listed_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [TIME_BITS-1:0]  decay_r;
  logic [TIME_BITS-1:0]  first_seen_r;
  logic [COUNT_BITS-1:0] total_r;
  logic                  blocked_r, blocked_nxt;

  logic                  in_xfer;
  logic                  adv;
  logic [TIME_BITS-1:0]  first_seen_nxt;
  logic [COUNT_BITS-1:0] total_nxt;
  logic                  step_blocked;
  logic                  step_drop, step_attack, step_listed;
  logic [TIME_BITS-1:0]  step_decay;

  pfb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_if.valid),
    .wr_idx  (cfg_if.index),
    .wr_data (cfg_if.data),
    .cfg     (cfg)
  );

  pfb_step #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cfg            (cfg),
    .now            (now_r),
    .pre_accept     (pre_r),
    .privileged     (priv_r),
    .first_seen     (first_seen_r),
    .ping_total     (total_r),
    .blocked        (blocked_r),
    .first_seen_nxt (first_seen_nxt),
    .ping_total_nxt (total_nxt),
    .blocked_nxt    (step_blocked),
    .drop           (step_drop),
    .attack_seen    (step_attack),
    .listed_hit     (step_listed),
    .decay_at       (step_decay)
  );

  assign cfg_if.ready = 1'b1;

  assign adv         = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || adv;
  assign in_xfer     = in_if.valid && in_if.ready;

  assign in_vld_nxt  = in_xfer ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? 1'b1 : (out_if.ready ? 1'b0 : out_vld_r);
  assign blocked_nxt = cfg.preset_load ? cfg.preset_val : (adv ? step_blocked : blocked_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      first_seen_r <= '0;
      total_r      <= '0;
      blocked_r    <= BLOCKED_RST;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      blocked_r <= blocked_nxt;
      if (adv) begin
        first_seen_r <= first_seen_nxt;
        total_r      <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r  <= in_if.now;
      pre_r  <= in_if.pre_accept;
      priv_r <= in_if.privileged;
    end
    if (adv) begin
      drop_r   <= step_drop;
      attack_r <= step_attack;
      listed_r <= step_listed;
      count_r  <= total_nxt;
      decay_r  <= step_decay;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.drop        = drop_r;
  assign out_if.attack_seen = attack_r;
  assign out_if.listed_hit  = listed_r;
  assign out_if.count_now   = count_r;
  assign out_if.decay_at    = decay_r;

endmodule

`default_nettype wire

>>> hw/rtl/pfb_checker.sv
// port-level checks of the ping flood blocker and their bind
`default_nettype none

module pfb_checker #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  drop,
  input wire logic                  attack_seen,
  input wire logic                  listed_hit,
  input wire logic [COUNT_BITS-1:0] count_now,
  input wire logic [TIME_BITS-1:0]  decay_at
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(decay_at) && $stable(count_now))
    else $error("result changed while stalled");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_now != '0)
    else $error("result count is zero");

  a_attack_drops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && attack_seen |-> drop && !listed_hit)
    else $error("attack without drop or with listed hit");

  a_listed_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && listed_hit |-> drop && (count_now == COUNT_BITS'(1)))
    else $error("listed hit not on a dropped first ping");

endmodule

bind ping_flood_blocker pfb_checker #(
  .TIME_BITS  (TIME_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_pfb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .drop        (out_if.drop),
  .attack_seen (out_if.attack_seen),
  .listed_hit  (out_if.listed_hit),
  .count_now   (out_if.count_now),
  .decay_at    (out_if.decay_at)
);

`default_nettype wire
